>>> design/sih_pkg.sv
package sih_pkg;

	localparam int STORE_BYTES = 4096;
	localparam int TABLE_SLOTS = 256;
	localparam int MAX_LEN = 255;

	localparam int AW = $clog2(STORE_BYTES);
	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int LW = $clog2(MAX_LEN + 2);
	localparam int FW = $clog2(STORE_BYTES + 1);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int KW = $clog2(MAX_LEN);

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic [2:0] ST_FOUND = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_TABLE_FULL = 3'd2;
	localparam logic [2:0] ST_STORE_FULL = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic absorb;      // fold the input byte into hash and staging
		logic start;       // latch hash and length, set the probe slot
		logic slot_rd;     // read the slot table at the probe slot
		logic next_slot;   // step the probe slot
		logic cmp_begin;   // clear the compare index
		logic cmp_rd;      // read store and staging at compare index
		logic cmp_step;    // advance the compare index
		logic wr_begin;    // clear the copy index
		logic wr_step;     // write one byte into the store
		logic commit;      // record the new slot and advance the fill
		logic clear_str;   // return the hash and length to reset values
	} sih_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic too_long;
		logic slot_valid;
		logic meta_match;
		logic cmp_done;
		logic cmp_equal;
		logic wr_done;
		logic table_full;
		logic store_full;
		logic probe_wrapped;
	} sih_sts_t;

endpackage

>>> design/sih_ctrl.sv
module sih_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               has_byte,
	input  logic               last,
	input  logic               out_slot_free,
	input  sih_pkg::sih_sts_t  sts,
	output sih_pkg::sih_cmd_t  cmd,
	output logic               res_load,
	output logic [2:0]         res_status,
	output logic               res_use_slot_off
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_START  = 9'b000000010,
		S_SLOT   = 9'b000000100,
		S_CHECK  = 9'b000001000,
		S_CMPRD  = 9'b000010000,
		S_CMP    = 9'b000100000,
		S_WRITE  = 9'b001000000,
		S_COMMIT = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] stat_q, stat_d;
	logic use_off_q, use_off_d;

	assign in_ready = (state_q == S_IDLE);
	assign res_status = stat_q;
	assign res_use_slot_off = use_off_q;

	always_comb begin
		state_d = state_q;
		stat_d = stat_q;
		use_off_d = use_off_q;
		cmd = '0;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.absorb = has_byte;
					if (last) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d = S_SLOT;
			end
			S_SLOT: begin
				if (sts.too_long) begin
					stat_d = sih_pkg::ST_TOO_LONG;
					use_off_d = 1'b0;
					state_d = S_DONE;
				end else begin
					cmd.slot_rd = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.slot_valid) begin
					if (sts.table_full) begin
						stat_d = sih_pkg::ST_TABLE_FULL;
						use_off_d = 1'b0;
						state_d = S_DONE;
					end else if (sts.store_full) begin
						stat_d = sih_pkg::ST_STORE_FULL;
						use_off_d = 1'b0;
						state_d = S_DONE;
					end else begin
						cmd.wr_begin = 1'b1;
						state_d = S_WRITE;
					end
				end else if (sts.meta_match) begin
					cmd.cmp_begin = 1'b1;
					state_d = S_CMPRD;
				end else begin
					cmd.next_slot = 1'b1;
					if (sts.probe_wrapped) begin
						stat_d = sih_pkg::ST_TABLE_FULL;
						use_off_d = 1'b0;
						state_d = S_DONE;
					end else begin
						state_d = S_SLOT;
					end
				end
			end
			S_CMPRD: begin
				if (sts.cmp_done) begin
					stat_d = sih_pkg::ST_FOUND;
					use_off_d = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.cmp_rd = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.cmp_equal) begin
					cmd.cmp_step = 1'b1;
					state_d = S_CMPRD;
				end else begin
					cmd.next_slot = 1'b1;
					if (sts.probe_wrapped) begin
						stat_d = sih_pkg::ST_TABLE_FULL;
						use_off_d = 1'b0;
						state_d = S_DONE;
					end else begin
						state_d = S_SLOT;
					end
				end
			end
			S_WRITE: begin
				cmd.wr_step = 1'b1;
				if (sts.wr_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				stat_d = sih_pkg::ST_INSERTED;
				use_off_d = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_slot_free) begin
					res_load = 1'b1;
					cmd.clear_str = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q <= sih_pkg::ST_FOUND;
			use_off_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stat_q <= stat_d;
			use_off_q <= use_off_d;
		end
	end

endmodule

>>> design/sih_dp.sv
module sih_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  byte_value,
	input  sih_pkg::sih_cmd_t           cmd,
	output sih_pkg::sih_sts_t           sts,
	output logic [31:0]                 hash_out,
	output logic [7:0]                  len_out,
	output logic [sih_pkg::AW-1:0]      new_off,
	output logic [sih_pkg::AW-1:0]      slot_off
);

	localparam int AW = sih_pkg::AW;
	localparam int SW = sih_pkg::SW;
	localparam int LW = sih_pkg::LW;
	localparam int FW = sih_pkg::FW;
	localparam int CW = sih_pkg::CW;
	localparam int KW = sih_pkg::KW;

	// Memories.
	logic [7:0] store_mem [sih_pkg::STORE_BYTES];
	logic [7:0] stage_mem [sih_pkg::MAX_LEN];
	logic [AW+LW+32-1:0] slot_mem [sih_pkg::TABLE_SLOTS];
	logic [sih_pkg::TABLE_SLOTS-1:0] valid_q;

	logic [31:0] hash_q, hash_s1;
	logic [LW-1:0] len_q, len_s1;
	logic [FW-1:0] fill_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] probe_q, probe_start_q;
	logic [LW-1:0] idx_q, idx_d;
	logic slot_v_q;
	logic [AW+LW+32-1:0] slot_q;
	logic [7:0] sbyte_q, gbyte_q;
	logic [7:0] stage_rd_q;
	logic [AW-1:0] wr_addr;
	logic [7:0] wr_data;
	logic [FW+1:0] need;

	assign slot_off = slot_q[AW+LW+32-1 -: AW];
	assign hash_out = hash_s1;
	assign len_out = (len_s1 > LW'(sih_pkg::MAX_LEN)) ? 8'(sih_pkg::MAX_LEN) : 8'(len_s1);
	assign new_off = fill_q[AW-1:0];

	assign need = (FW+2)'(fill_q) + (FW+2)'(len_s1) + (FW+2)'(1);

	always_comb begin
		sts.too_long = len_s1 > LW'(sih_pkg::MAX_LEN);
		sts.slot_valid = slot_v_q;
		sts.meta_match = (slot_q[31:0] == hash_s1)
			&& (slot_q[32 +: LW] == len_s1);
		sts.cmp_done = idx_q == len_s1;
		sts.cmp_equal = sbyte_q == gbyte_q;
		sts.wr_done = idx_q == len_s1;
		sts.table_full = ((CW+2)'(count_q) << 2) >= (CW+2)'(sih_pkg::TABLE_SLOTS * 3);
		sts.store_full = need > (FW+2)'(sih_pkg::STORE_BYTES);
		sts.probe_wrapped = (probe_q + SW'(1)) == probe_start_q;
	end

	// Hash and staging.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sih_pkg::FNV_BASIS;
			len_q <= '0;
		end else if (cmd.clear_str) begin
			hash_q <= sih_pkg::FNV_BASIS;
			len_q <= '0;
		end else if (cmd.absorb) begin
			hash_q <= (hash_q ^ {24'd0, byte_value}) * sih_pkg::FNV_PRIME;
			if (len_q <= LW'(sih_pkg::MAX_LEN)) begin
				len_q <= len_q + LW'(1);
			end
		end
	end

	// The staging read is addressed with the next index, so stage_rd_q always
	// holds the staged byte at the current index.
	always_ff @(posedge clk) begin
		if (cmd.absorb && len_q < LW'(sih_pkg::MAX_LEN)) begin
			stage_mem[len_q[KW-1:0]] <= byte_value;
		end
		stage_rd_q <= stage_mem[idx_d[KW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hash_s1 <= hash_q;
			len_s1 <= len_q;
		end
	end

	// Probe control and slot table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			fill_q <= FW'(1);
			probe_q <= '0;
			probe_start_q <= '0;
			slot_v_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				probe_q <= hash_q[SW-1:0];
				probe_start_q <= hash_q[SW-1:0];
			end else if (cmd.next_slot) begin
				probe_q <= probe_q + SW'(1);
			end
			if (cmd.slot_rd) begin
				slot_v_q <= valid_q[probe_q];
			end
			if (cmd.commit) begin
				valid_q[probe_q] <= 1'b1;
				count_q <= count_q + CW'(1);
				fill_q <= FW'(need);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_mem[probe_q] <= {fill_q[AW-1:0], len_s1, hash_s1};
		end
		if (cmd.slot_rd) begin
			slot_q <= slot_mem[probe_q];
		end
	end

	// Byte compare and copy.
	assign wr_addr = AW'(fill_q[AW-1:0] + AW'(idx_q));
	assign wr_data = (idx_q == len_s1) ? 8'd0 : stage_rd_q;

	always_comb begin
		idx_d = idx_q;
		if (cmd.cmp_begin || cmd.wr_begin) begin
			idx_d = '0;
		end else if (cmd.cmp_step || (cmd.wr_step && !sts.wr_done)) begin
			idx_d = idx_q + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			idx_q <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_step) begin
			store_mem[wr_addr] <= wr_data;
		end
		if (cmd.cmp_rd) begin
			sbyte_q <= store_mem[AW'(slot_off + AW'(idx_q))];
			gbyte_q <= stage_rd_q;
		end
	end

endmodule

>>> design/string_intern_hash_table_top.sv
// String interning table.
// Input channel (in_valid/in_ready) takes one request per string byte:
// byte_value, has_byte and last. A request with has_byte set folds the
// byte into an FNV-1a hash; the request with last set ends the string.
// Output channel (out_valid/out_ready) returns one result per string:
// string_id, status, string_hash and string_length.
// Byte requests are accepted while the sequencer is idle. The final
// request then probes the slot table linearly, visiting each slot in the
// SLOT and CHECK states and comparing each stored byte in the CMPRD and
// CMP states on a hash and length hit; an insert copies length + 1
// bytes, one per cycle. The sequencer handles one string at a time.
// The result sits in an output register, so the next string may start
// while it waits; a further result waits until out_ready takes the first.
// Reset clears the slot valid bits, the length and the entry count, and
// sets the hash and the store fill to their start values at once; no clearing pass is needed.
module string_intern_hash_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        has_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] string_id,
	output logic [2:0]  status,
	output logic [31:0] string_hash,
	output logic [7:0]  string_length
);

	sih_pkg::sih_cmd_t cmd;
	sih_pkg::sih_sts_t sts;
	logic res_load;
	logic [2:0] res_status;
	logic res_use_off;
	logic [31:0] hash_w;
	logic [7:0] len_w;
	logic [sih_pkg::AW-1:0] new_off;
	logic [sih_pkg::AW-1:0] slot_off;
	logic out_free;

	// The output register is free when empty or being drained this cycle.
	assign out_free = !out_valid || out_ready;

	sih_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.has_byte(has_byte),
		.last(last),
		.out_slot_free(out_free),
		.sts(sts),
		.cmd(cmd),
		.res_load(res_load),
		.res_status(res_status),
		.res_use_slot_off(res_use_off)
	);

	sih_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.byte_value(byte_value),
		.cmd(cmd),
		.sts(sts),
		.hash_out(hash_w),
		.len_out(len_w),
		.new_off(new_off),
		.slot_off(slot_off)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// A found string reports the slot's offset; an insert reports the
	// offset it was written at, which the commit has already moved past,
	// so the slot read holds it only for a found string. Inserted results
	// take the previous fill through the latched copy below.
	logic [11:0] ins_off_q;
	always_ff @(posedge clk) begin
		if (cmd.wr_begin) begin
			ins_off_q <= 12'(new_off);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			string_hash <= hash_w;
			string_length <= len_w;
			status <= res_status;
			if (!res_use_off) begin
				string_id <= '0;
			end else if (res_status == sih_pkg::ST_INSERTED) begin
				string_id <= ins_off_q;
			end else begin
				string_id <= 12'(slot_off);
			end
		end
	end

endmodule
